/* hw/rtl/ir_range_sample_to_distance_macros.svh */
// Assertion macros shared by the range converter RTL.
`ifndef IR_RANGE_SAMPLE_TO_DISTANCE_MACROS_SVH
`define IR_RANGE_SAMPLE_TO_DISTANCE_MACROS_SVH

`ifndef SYNTHESIS
`define IRSD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("irsd assertion failed");
`define IRSD_ASSERT_AT(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("irsd assertion failed");
`else
`define IRSD_ASSERT(lbl, clk, rst_n, prop)
`define IRSD_ASSERT_AT(lbl, clk, prop)
`endif

`endif

/* hw/rtl/irsd_pkg.sv */
// Shared widths, constants, types and control structs of the range converter.
package irsd_pkg;

    localparam int RAW_W       = 12;
    localparam int SCALE_W     = 16;
    localparam int OFFSET_W    = 22;
    localparam int DIST_W      = 15;
    localparam int PROD_W      = 29;
    localparam int ADJ_W       = 29;
    localparam int DIVR_W      = 28;
    localparam int QUO_W       = 15;
    localparam int STEP_W      = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 22;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 16;

    localparam int WINDOW_LEN_DEF = 5;

    localparam logic signed [SCALE_W-1:0]  SCALE_RST  = 16'sd256;
    localparam logic signed [OFFSET_W-1:0] OFFSET_RST = '0;
    localparam logic                       FILT_RST   = 1'b1;

    // 12000 * 65536 = NUM_HI * 2^15, low 15 bits zero
    localparam int NUM_HI = 24000;

    localparam logic [DIST_W-1:0] DIST_MAX = 15'd20480;
    localparam logic [DIST_W-1:0] DIST_MIN = 15'd2560;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE  = 2'd0,
        CFG_OFFSET = 2'd1,
        CFG_FILTER = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_CONV,
        ST_DIV_CONV,
        ST_CLAMP,
        ST_FILT,
        ST_SUM,
        ST_AVG_LD,
        ST_DIV_AVG,
        ST_AVG_TAKE,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic load_in;
        logic mul;
        logic add;
        logic set_max;
        logic div_ld_conv;
        logic div_ld_avg;
        logic div_step;
        logic take_conv;
        logic shift_win;
        logic sum_step;
        logic take_avg;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic failed;
        logic adj_sat;
        logic filter_en;
        logic div_last;
        logic sum_last;
    } status_t;

endpackage

/* hw/rtl/irsd_ctrl.sv */
// Sequencing state machine and stream handshakes of the range converter.
`include "ir_range_sample_to_distance_macros.svh"

module irsd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  irsd_pkg::status_t status,
    output irsd_pkg::cmd_t    cmd
);

    irsd_pkg::state_t state_reg, state_next;
    logic             m_tvalid_reg, m_tvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= irsd_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            irsd_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = irsd_pkg::ST_MUL;
                end
            end
            irsd_pkg::ST_MUL: begin
                if (status.failed) begin
                    state_next = irsd_pkg::ST_FIN;
                end else begin
                    cmd.mul    = 1'b1;
                    state_next = irsd_pkg::ST_ADD;
                end
            end
            irsd_pkg::ST_ADD: begin
                cmd.add    = 1'b1;
                state_next = irsd_pkg::ST_CONV;
            end
            irsd_pkg::ST_CONV: begin
                if (status.adj_sat) begin
                    cmd.set_max = 1'b1;
                    state_next  = irsd_pkg::ST_FILT;
                end else begin
                    cmd.div_ld_conv = 1'b1;
                    state_next      = irsd_pkg::ST_DIV_CONV;
                end
            end
            irsd_pkg::ST_DIV_CONV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = irsd_pkg::ST_CLAMP;
                end
            end
            irsd_pkg::ST_CLAMP: begin
                cmd.take_conv = 1'b1;
                state_next    = irsd_pkg::ST_FILT;
            end
            irsd_pkg::ST_FILT: begin
                if (status.filter_en) begin
                    cmd.shift_win = 1'b1;
                    state_next    = irsd_pkg::ST_SUM;
                end else begin
                    state_next = irsd_pkg::ST_FIN;
                end
            end
            irsd_pkg::ST_SUM: begin
                cmd.sum_step = 1'b1;
                if (status.sum_last) begin
                    state_next = irsd_pkg::ST_AVG_LD;
                end
            end
            irsd_pkg::ST_AVG_LD: begin
                cmd.div_ld_avg = 1'b1;
                state_next     = irsd_pkg::ST_DIV_AVG;
            end
            irsd_pkg::ST_DIV_AVG: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = irsd_pkg::ST_AVG_TAKE;
                end
            end
            irsd_pkg::ST_AVG_TAKE: begin
                cmd.take_avg = 1'b1;
                state_next   = irsd_pkg::ST_FIN;
            end
            irsd_pkg::ST_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = irsd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = irsd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    assign s_tready = (state_reg == irsd_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    `IRSD_ASSERT(a_fin_holds, aclk, aresetn,
        (state_reg == irsd_pkg::ST_FIN && m_tvalid_reg && !m_tready) |=>
        (state_reg == irsd_pkg::ST_FIN))
    `IRSD_ASSERT_AT(a_accept_starts, aclk,
        (aresetn && s_tvalid && s_tready) |=> (state_reg == irsd_pkg::ST_MUL))

endmodule

/* hw/rtl/irsd_datapath.sv */
// Config registers, multiply-add, shared restoring divider and averaging window.
`include "ir_range_sample_to_distance_macros.svh"

module irsd_datapath #(
    parameter int WINDOW_LEN = irsd_pkg::WINDOW_LEN_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [irsd_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tuser,
    input  logic                            cfg_we,
    input  logic [irsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [irsd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  irsd_pkg::cmd_t                  cmd,
    output irsd_pkg::status_t               status,
    output logic [irsd_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tuser
);

    localparam int CNT_W = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W = irsd_pkg::DIST_W + CNT_W;
    localparam int IDX_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

    logic signed [irsd_pkg::SCALE_W-1:0]  scale_reg;
    logic signed [irsd_pkg::OFFSET_W-1:0] offset_reg;
    logic                                 filt_reg;

    logic [irsd_pkg::RAW_W-1:0]          raw_reg;
    logic                                fail_reg;
    logic signed [irsd_pkg::PROD_W-1:0]  prod_reg, prod_next;
    logic signed [irsd_pkg::PROD_W-1:0]  raw_ext, scale_ext;
    logic signed [irsd_pkg::ADJ_W-1:0]   adj_reg, adj_next;

    logic [irsd_pkg::DIVR_W-1:0] rem_reg, rem_next;
    logic [irsd_pkg::DIVR_W-1:0] dvs_reg;
    logic [irsd_pkg::QUO_W-1:0]  quo_reg;
    logic [irsd_pkg::STEP_W-1:0] step_reg;
    logic [irsd_pkg::DIVR_W:0]   trial, diff;
    logic                        ge;

    logic [irsd_pkg::DIST_W-1:0] dist_reg, dist_clamp;
    logic [irsd_pkg::DIST_W-1:0] win_reg [WINDOW_LEN];
    logic [irsd_pkg::DIST_W-1:0] win_sel;
    logic [IDX_W-1:0]            idx_reg;
    logic [SUM_W-1:0]            sum_reg;
    logic [CNT_W-1:0]            cnt_reg;

    logic [irsd_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                           m_tuser_reg;

    // configuration and window (a filter_enable write empties the window)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg  <= irsd_pkg::SCALE_RST;
            offset_reg <= irsd_pkg::OFFSET_RST;
            filt_reg   <= irsd_pkg::FILT_RST;
            for (int i = 0; i < WINDOW_LEN; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                case (irsd_pkg::cfg_idx_t'(cfg_index))
                    irsd_pkg::CFG_SCALE: begin
                        scale_reg <= cfg_data[irsd_pkg::SCALE_W-1:0];
                    end
                    irsd_pkg::CFG_OFFSET: begin
                        offset_reg <= cfg_data[irsd_pkg::OFFSET_W-1:0];
                    end
                    irsd_pkg::CFG_FILTER: begin
                        filt_reg <= cfg_data[0];
                        for (int i = 0; i < WINDOW_LEN; i++) begin
                            win_reg[i] <= '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end else if (cmd.shift_win) begin
                for (int i = 0; i < WINDOW_LEN - 1; i++) begin
                    win_reg[i] <= win_reg[i + 1];
                end
                win_reg[WINDOW_LEN - 1] <= dist_reg;
            end
        end
    end

    assign raw_ext   = irsd_pkg::PROD_W'($signed({1'b0, raw_reg}));
    assign scale_ext = irsd_pkg::PROD_W'(scale_reg);
    assign prod_next = raw_ext * scale_ext;
    assign adj_next  = prod_reg + irsd_pkg::ADJ_W'(offset_reg);

    // one restoring step per cycle; low dividend bits shift in through quo_reg
    assign trial    = {rem_reg, quo_reg[irsd_pkg::QUO_W-1]};
    assign diff     = trial - {1'b0, dvs_reg};
    assign ge       = (trial >= {1'b0, dvs_reg});
    assign rem_next = ge ? diff[irsd_pkg::DIVR_W-1:0] : trial[irsd_pkg::DIVR_W-1:0];

    always_comb begin
        dist_clamp = quo_reg;
        if (quo_reg > irsd_pkg::DIST_MAX) begin
            dist_clamp = irsd_pkg::DIST_MAX;
        end else if (quo_reg < irsd_pkg::DIST_MIN) begin
            dist_clamp = irsd_pkg::DIST_MIN;
        end
    end

    assign win_sel = win_reg[idx_reg];

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            raw_reg  <= s_tdata[irsd_pkg::RAW_W-1:0];
            fail_reg <= s_tuser;
        end
        if (cmd.mul) begin
            prod_reg <= prod_next;
        end
        if (cmd.add) begin
            adj_reg <= adj_next;
        end
        if (cmd.div_ld_conv) begin
            rem_reg  <= irsd_pkg::DIVR_W'(irsd_pkg::NUM_HI);
            quo_reg  <= '0;
            dvs_reg  <= adj_reg[irsd_pkg::DIVR_W-1:0];
            step_reg <= '0;
        end else if (cmd.div_ld_avg) begin
            rem_reg  <= irsd_pkg::DIVR_W'(sum_reg[SUM_W-1:irsd_pkg::QUO_W]);
            quo_reg  <= sum_reg[irsd_pkg::QUO_W-1:0];
            dvs_reg  <= irsd_pkg::DIVR_W'(cnt_reg);
            step_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg  <= rem_next;
            quo_reg  <= {quo_reg[irsd_pkg::QUO_W-2:0], ge};
            step_reg <= step_reg + irsd_pkg::STEP_W'(1);
        end
        if (cmd.set_max) begin
            dist_reg <= irsd_pkg::DIST_MAX;
        end else if (cmd.take_conv) begin
            dist_reg <= dist_clamp;
        end else if (cmd.take_avg) begin
            dist_reg <= quo_reg;
        end
        if (cmd.shift_win) begin
            idx_reg <= '0;
            sum_reg <= '0;
            cnt_reg <= '0;
        end else if (cmd.sum_step) begin
            idx_reg <= idx_reg + IDX_W'(1);
            if (win_sel != '0) begin
                sum_reg <= sum_reg + SUM_W'(win_sel);
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
        if (cmd.out_load) begin
            m_tdata_reg <= fail_reg ? '0 : irsd_pkg::M_TDATA_W'(dist_reg);
            m_tuser_reg <= !fail_reg;
        end
    end

    assign status.failed    = fail_reg;
    assign status.adj_sat   = (adj_reg <= irsd_pkg::ADJ_W'(irsd_pkg::NUM_HI));
    assign status.filter_en = filt_reg;
    assign status.div_last  = (step_reg == irsd_pkg::STEP_W'(irsd_pkg::QUO_W - 1));
    assign status.sum_last  = (idx_reg == IDX_W'(WINDOW_LEN - 1));

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

    `IRSD_ASSERT(a_conv_range, aclk, aresetn,
        cmd.take_conv |=> (dist_reg >= irsd_pkg::DIST_MIN && dist_reg <= irsd_pkg::DIST_MAX))
    `IRSD_ASSERT(a_avg_range, aclk, aresetn,
        cmd.take_avg |=> (dist_reg >= irsd_pkg::DIST_MIN && dist_reg <= irsd_pkg::DIST_MAX))

endmodule

/* hw/rtl/ir_range_sample_to_distance.sv */
// Top level: IR range sample to distance converter with moving-average window.
// A new sample is accepted only while idle, so one transaction runs at a time; the
//   15-step restoring divider runs for 12000/x unless the result saturates to DIST_MAX,
//   and once more for the window mean when the filter is on. A read failure skips both.
// Reset (aresetn low, synchronous): scale 1.0, offset 0, filter on, window empty.
module ir_range_sample_to_distance #(
    parameter int WINDOW_LEN = irsd_pkg::WINDOW_LEN_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [irsd_pkg::S_TDATA_W-1:0]  s_tdata,   // [11:0] raw_sample
    input  logic                            s_tuser,   // [0] read_failed
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [irsd_pkg::M_TDATA_W-1:0]  m_tdata,   // [14:0] distance
    output logic                            m_tuser,   // [0] valid_res
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [irsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [irsd_pkg::CFG_DATA_W-1:0] cfg_data
);

    irsd_pkg::cmd_t    cmd;
    irsd_pkg::status_t status;

    assign cfg_ready = 1'b1;

    irsd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    irsd_datapath #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
